// File: hw/rtl/gdoy_pkg.sv
// Shared constants and calendar tables for the day-of-year converter.
package gdoy_pkg;

  // Result status codes.
  localparam logic [1:0] StatusOk         = 2'd0;
  localparam logic [1:0] StatusBadMonth   = 2'd1;
  localparam logic [1:0] StatusBadDay     = 2'd2;
  localparam logic [1:0] StatusBadOrdinal = 2'd3;

  // Field widths.
  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int OrdW   = 9;

  // Divisibility by 25 of a 14-bit year: multiply by the inverse of 25
  // modulo 2^14 and compare against floor((2^14 - 1) / 25).
  localparam logic [YearW-1:0] Inv25 = 14'd7209;
  localparam logic [YearW-1:0] Div25Limit = YearW'(((1 << YearW) - 1) / 25);

  // Year lengths.
  localparam logic [OrdW-1:0] CommonYearLen = 9'd365;
  localparam logic [OrdW-1:0] LeapYearLen   = 9'd366;

  // Candidate months found by the ordinal search, one per year type.
  typedef struct packed {
    logic [MonthW-1:0] common_month;
    logic [MonthW-1:0] leap_month;
  } month_pick_t;

  // Days before month m in a common year.
  function automatic logic [OrdW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [OrdW-1:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Days before month m, with the leap day counted after February.
  function automatic logic [OrdW-1:0] start_of(input logic [MonthW-1:0] m,
                                               input logic leap);
    logic [OrdW-1:0] s;
    s = days_before(m);
    if (leap && (m > 4'd2)) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

  // Length of month m; February has 29 days in a leap year.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: hw/rtl/gdoy_month_search.sv
// Finds the month that holds an ordinal day, for a common and a leap year.
// The month is one plus the number of month starts that the ordinal passes.
module gdoy_month_search (
  input  logic [gdoy_pkg::OrdW-1:0] ordinal,
  output gdoy_pkg::month_pick_t     pick
);

  logic [10:0] past_common;
  logic [10:0] past_leap;

  // Compare against the start of every month from February on.
  always_comb begin
    for (int k = 0; k < 11; k++) begin
      past_common[k] = ordinal > gdoy_pkg::start_of(4'(k + 2), 1'b0);
      past_leap[k]   = ordinal > gdoy_pkg::start_of(4'(k + 2), 1'b1);
    end
  end

  assign pick.common_month = 4'd1 + 4'($countones(past_common));
  assign pick.leap_month   = 4'd1 + 4'($countones(past_leap));

endmodule

// File: hw/rtl/gregorian_day_of_year_converter_core.sv
// Gregorian day-of-year converter, three register stages.
// Throughput: one item per cycle; the whole pipeline stalls while a result waits.
// Stage 1 holds the year product for the divide-by-25 test, stage 2 the month
// lookup, stage 3 the result. Synchronous active-high reset clears valid bits only.
module gregorian_day_of_year_converter_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [gdoy_pkg::YearW-1:0]  year,
  input  logic [gdoy_pkg::MonthW-1:0] month_in,
  input  logic [gdoy_pkg::DayW-1:0]   day_in,
  input  logic [gdoy_pkg::OrdW-1:0]   ordinal_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gdoy_pkg::OrdW-1:0]   ordinal_out,
  output logic [gdoy_pkg::MonthW-1:0] month_out,
  output logic [gdoy_pkg::DayW-1:0]   day_out,
  output logic                        is_leap,
  output logic [1:0]                  status
);

  logic advance;

  // Stage 1 registers.
  logic                        s1_valid;
  logic                        s1_kind;
  logic [3:0]                  s1_year_lo;
  logic [gdoy_pkg::YearW-1:0]  s1_prod;
  logic [gdoy_pkg::MonthW-1:0] s1_month;
  logic [gdoy_pkg::DayW-1:0]   s1_day;
  logic [gdoy_pkg::OrdW-1:0]   s1_ord;
  gdoy_pkg::month_pick_t       s1_pick;

  // Stage 2 registers.
  logic                        s2_valid;
  logic                        s2_kind;
  logic                        s2_leap;
  logic                        s2_month_ok;
  logic [gdoy_pkg::DayW-1:0]   s2_day;
  logic [gdoy_pkg::OrdW-1:0]   s2_ord;
  logic [gdoy_pkg::MonthW-1:0] s2_month;
  logic [gdoy_pkg::OrdW-1:0]   s2_start;
  logic [gdoy_pkg::DayW-1:0]   s2_len;

  // Stage 1 and stage 2 combinational values.
  logic [gdoy_pkg::YearW-1:0]  prod_next;
  gdoy_pkg::month_pick_t       pick_next;
  logic                        leap_next;
  logic [gdoy_pkg::MonthW-1:0] month_next;

  // Result values.
  logic [gdoy_pkg::OrdW-1:0]   ord_res;
  logic [gdoy_pkg::MonthW-1:0] mon_res;
  logic [gdoy_pkg::DayW-1:0]   day_res;
  logic [1:0]                  status_res;
  logic [gdoy_pkg::OrdW-1:0]   year_len;
  logic [gdoy_pkg::OrdW-1:0]   day_diff;

  // The pipeline moves as one whenever the output register is free.
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // Stage 1 logic: year times the inverse of 25, and the ordinal search.
  assign prod_next = gdoy_pkg::YearW'(year * gdoy_pkg::Inv25);

  gdoy_month_search u_search (
    .ordinal (ordinal_in),
    .pick    (pick_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
    if (advance) begin
      s1_kind    <= kind;
      s1_year_lo <= year[3:0];
      s1_prod    <= prod_next;
      s1_month   <= month_in;
      s1_day     <= day_in;
      s1_ord     <= ordinal_in;
      s1_pick    <= pick_next;
    end
  end

  // Stage 2 logic: leap decision, month choice and month table lookup.
  // Divisible by 100 means by 4 and 25; divisible by 400 means by 16 and 25.
  assign leap_next = (s1_year_lo[1:0] == 2'd0) &&
                     ((s1_prod > gdoy_pkg::Div25Limit) || (s1_year_lo == 4'd0));

  always_comb begin
    if (s1_kind) begin
      month_next = leap_next ? s1_pick.leap_month : s1_pick.common_month;
    end else begin
      month_next = s1_month;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
    if (advance) begin
      s2_kind     <= s1_kind;
      s2_leap     <= leap_next;
      s2_month_ok <= (s1_month >= 4'd1) && (s1_month <= 4'd12);
      s2_day      <= s1_day;
      s2_ord      <= s1_ord;
      s2_month    <= month_next;
      s2_start    <= gdoy_pkg::start_of(month_next, leap_next);
      s2_len      <= gdoy_pkg::month_len(month_next, leap_next);
    end
  end

  // Stage 3 logic: range checks and the final add or subtract.
  assign year_len = s2_leap ? gdoy_pkg::LeapYearLen : gdoy_pkg::CommonYearLen;
  assign day_diff = s2_ord - s2_start;

  always_comb begin
    ord_res    = '0;
    mon_res    = '0;
    day_res    = '0;
    status_res = gdoy_pkg::StatusOk;
    if (!s2_kind) begin
      priority if (!s2_month_ok) begin
        status_res = gdoy_pkg::StatusBadMonth;
      end else if ((s2_day == 5'd0) || (s2_day > s2_len)) begin
        status_res = gdoy_pkg::StatusBadDay;
      end else begin
        ord_res = s2_start + gdoy_pkg::OrdW'(s2_day);
      end
    end else begin
      if ((s2_ord == 9'd0) || (s2_ord > year_len)) begin
        status_res = gdoy_pkg::StatusBadOrdinal;
      end else begin
        mon_res = s2_month;
        day_res = day_diff[gdoy_pkg::DayW-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
    if (advance) begin
      ordinal_out <= ord_res;
      month_out   <= mon_res;
      day_out     <= day_res;
      is_leap     <= s2_leap;
      status      <= status_res;
    end
  end

endmodule

// File: hw/rtl/gdoy_checker.sv
// Port-level checks for the day-of-year converter.
module gdoy_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gdoy_pkg::OrdW-1:0]   ordinal_out,
  input logic [gdoy_pkg::MonthW-1:0] month_out,
  input logic [gdoy_pkg::DayW-1:0]   day_out,
  input logic                        is_leap,
  input logic [1:0]                  status
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ordinal_out) &&
      $stable(month_out) && $stable(day_out) && $stable(is_leap) && $stable(status))
    else $error("stalled result changed");

  // The pipeline takes no item while the output is blocked.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");

  // An error result carries no date.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != gdoy_pkg::StatusOk) |->
      (ordinal_out == 9'd0) && (month_out == 4'd0) && (day_out == 5'd0))
    else $error("error result with nonzero date");

  // A date result has a legal month and day and no ordinal.
  a_date: assert property (@(posedge clk) disable iff (rst)
    out_valid && (month_out != 4'd0) |->
      (month_out <= 4'd12) && (day_out != 5'd0) && (ordinal_out == 9'd0))
    else $error("malformed date result");

  // An ordinal result stays within the year.
  a_ord: assert property (@(posedge clk) disable iff (rst)
    out_valid && (ordinal_out != 9'd0) |->
      (month_out == 4'd0) && ((ordinal_out <= 9'd365) || (is_leap && ordinal_out == 9'd366)))
    else $error("ordinal result out of range");

endmodule

bind gregorian_day_of_year_converter_core gdoy_checker u_gdoy_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .ordinal_out (ordinal_out),
  .month_out   (month_out),
  .day_out     (day_out),
  .is_leap     (is_leap),
  .status      (status)
);
